@@ design/kdq_pkg.sv @@
package kdq_pkg;

   localparam int KeyFieldBits = 32;
   localparam int CountFieldBits = 5;

   localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [2:0] OP_POP_FRONT  = 3'd2;
   localparam logic [2:0] OP_POP_BACK   = 3'd3;
   localparam logic [2:0] OP_LOOKUP     = 3'd4;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   typedef struct packed {
      logic [2:0]              op;
      logic [KeyFieldBits-1:0] key;
   } req_type;

   typedef struct packed {
      logic [1:0]                status;
      logic                      found;
      logic [CountFieldBits-1:0] entry_count;
   } rsp_type;

   // per-cell move controls
   typedef struct packed {
      logic shift_right;
      logic shift_left;
      logic load;
      logic drop;
   } cell_ctrl_type;

endpackage

@@ design/kdq_cell.sv @@
module kdq_cell #(
   parameter int KEY_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  kdq_pkg::cell_ctrl_type ctrl,
   input  logic [KEY_BITS-1:0]  new_key,
   input  logic [KEY_BITS-1:0]  left_key,
   input  logic                 left_valid,
   input  logic [KEY_BITS-1:0]  right_key,
   input  logic                 right_valid,
   input  logic [KEY_BITS-1:0]  search_key,
   output logic [KEY_BITS-1:0]  key_out,
   output logic                 valid_out,
   output logic                 match
);

   logic [KEY_BITS-1:0] key_ff, key_in;
   logic                valid_ff, valid_in;

   always_comb begin
      key_in   = key_ff;
      valid_in = valid_ff;
      if (ctrl.shift_right) begin
         key_in   = left_key;
         valid_in = left_valid;
      end else if (ctrl.shift_left) begin
         key_in   = right_key;
         valid_in = right_valid;
      end else if (ctrl.load) begin
         key_in   = new_key;
         valid_in = 1'b1;
      end else if (ctrl.drop) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      key_ff <= key_in;
   end

   assign key_out   = key_ff;
   assign valid_out = valid_ff;
   assign match     = valid_ff && (key_ff == search_key);

endmodule

@@ design/keyed_double_ended_queue_unit.sv @@
// Latency: a result is registered and appears in the cycle after its request beat is taken.
// Throughput: one request per cycle; the single result register stalls the
// request side only while a held result is itself stalled.
// Lookup compares every cell of the chain in the same cycle.
// Reset (synchronous): all cells read empty, count zero, no result pending.
module keyed_double_ended_queue_unit #(
   parameter int DEPTH    = 16,
   parameter int KEY_BITS = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  kdq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output kdq_pkg::rsp_type rsp_data
);

   localparam int CountBits = $clog2(DEPTH + 1);

   logic [CountBits-1:0]  count_ff, count_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   kdq_pkg::rsp_type      rsp_data_ff, rsp_data_in;

   logic                  accept;
   logic                  full, empty;
   logic [KEY_BITS-1:0]   key_ext;
   logic [KEY_BITS-1:0]   cell_key [DEPTH];
   logic [DEPTH-1:0]      cell_valid;
   logic [DEPTH-1:0]      cell_match;
   kdq_pkg::cell_ctrl_type cell_ctrl [DEPTH];

   generate
      if (KEY_BITS >= kdq_pkg::KeyFieldBits) begin : g_key_wide
         assign key_ext = KEY_BITS'(req_data.key);
      end else begin : g_key_narrow
         assign key_ext = req_data.key[KEY_BITS-1:0];
      end
   endgenerate

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign full      = (count_ff == CountBits'(DEPTH));
   assign empty     = (count_ff == '0);

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         cell_ctrl[i].shift_right = accept && (req_data.op == kdq_pkg::OP_PUSH_FRONT) && !full;
         cell_ctrl[i].shift_left  = accept && (req_data.op == kdq_pkg::OP_POP_FRONT) && !empty;
         cell_ctrl[i].load        = accept && (req_data.op == kdq_pkg::OP_PUSH_BACK) && !full
                                    && (count_ff == CountBits'(i));
         cell_ctrl[i].drop        = accept && (req_data.op == kdq_pkg::OP_POP_BACK) && !empty
                                    && (count_ff == CountBits'(i + 1));
      end
   end

   generate
      for (genvar g = 0; g < DEPTH; g++) begin : g_cell
         logic [KEY_BITS-1:0] left_key, right_key;
         logic                left_valid, right_valid;

         if (g == 0) begin : g_head
            assign left_key   = key_ext;
            assign left_valid = 1'b1;
         end else begin : g_body_l
            assign left_key   = cell_key[g-1];
            assign left_valid = cell_valid[g-1];
         end

         if (g == DEPTH - 1) begin : g_tail
            assign right_key   = '0;
            assign right_valid = 1'b0;
         end else begin : g_body_r
            assign right_key   = cell_key[g+1];
            assign right_valid = cell_valid[g+1];
         end

         kdq_cell #(
            .KEY_BITS(KEY_BITS)
         ) u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (cell_ctrl[g]),
            .new_key    (key_ext),
            .left_key   (left_key),
            .left_valid (left_valid),
            .right_key  (right_key),
            .right_valid(right_valid),
            .search_key (key_ext),
            .key_out    (cell_key[g]),
            .valid_out  (cell_valid[g]),
            .match      (cell_match[g])
         );
      end
   endgenerate

   always_comb begin
      count_in    = count_ff;
      rsp_data_in = rsp_data_ff;
      if (accept) begin
         rsp_data_in.status = kdq_pkg::ST_OK;
         rsp_data_in.found  = 1'b0;
         case (req_data.op)
            kdq_pkg::OP_PUSH_FRONT, kdq_pkg::OP_PUSH_BACK: begin
               if (full) begin
                  rsp_data_in.status = kdq_pkg::ST_FULL;
               end else begin
                  count_in = count_ff + 1'b1;
               end
            end
            kdq_pkg::OP_POP_FRONT, kdq_pkg::OP_POP_BACK: begin
               if (empty) begin
                  rsp_data_in.status = kdq_pkg::ST_EMPTY;
               end else begin
                  count_in = count_ff - 1'b1;
               end
            end
            kdq_pkg::OP_LOOKUP: begin
               rsp_data_in.found = |cell_match;
            end
            default: begin
            end
         endcase
         rsp_data_in.entry_count = kdq_pkg::CountFieldBits'(count_in);
      end
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ design/kdq_checker.sv @@
module kdq_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input kdq_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input kdq_pkg::rsp_type rsp_data
);

   // stall only while a result is held back
   a_stall_needs_held: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("request stalled without a held result");

   // every taken request beat gives a result beat next cycle
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> rsp_valid)
      else $error("no result after a request beat");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result changed");

   a_found_only_lookup: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && (req_data.op != kdq_pkg::OP_LOOKUP))
      |=> !rsp_data.found)
      else $error("found set outside lookup");

   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.found) |-> (rsp_data.status == kdq_pkg::ST_OK))
      else $error("found with refused status");

endmodule

bind keyed_double_ended_queue_unit kdq_checker u_kdq_checker (
   .clock    (clock),
   .reset    (reset),
   .req_valid(req_valid),
   .req_stall(req_stall),
   .req_data (req_data),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_data (rsp_data)
);

@@ dv/kdq_deque_checker.sv @@
`timescale 1ns / 1ps

module kdq_deque_checker #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  kdq_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  kdq_pkg::rsp_type rsp_data,
   output int               fail_count,
   output int               pending_count,
   output int               refused_push_count,
   output int               refused_pop_count,
   output int               lookup_hit_count
);

   localparam int PrintLimit = 40;

   logic [kdq_pkg::KeyFieldBits-1:0] held_keys [QUEUE_DEPTH];
   int head_slot = 0;
   int held_count = 0;
   kdq_pkg::rsp_type awaited_results [$];
   int mismatches = 0;
   int full_refusals = 0;
   int empty_refusals = 0;
   int lookup_hits = 0;

   task automatic report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= PrintLimit) begin
         $display("%0t kdq mismatch: %s", $realtime, msg);
      end
   endtask

   // Apply one request to the shadow deque and return the result it must give.
   function automatic kdq_pkg::rsp_type apply_deque_op(input kdq_pkg::req_type beat);
      kdq_pkg::rsp_type outcome;
      outcome.status = kdq_pkg::ST_OK;
      outcome.found = 1'b0;
      case (beat.op)
         kdq_pkg::OP_PUSH_FRONT: begin
            if (held_count >= QUEUE_DEPTH) begin
               outcome.status = kdq_pkg::ST_FULL;
            end else begin
               head_slot = (head_slot + QUEUE_DEPTH - 1) % QUEUE_DEPTH;
               held_keys[head_slot] = beat.key;
               held_count++;
            end
         end
         kdq_pkg::OP_PUSH_BACK: begin
            if (held_count >= QUEUE_DEPTH) begin
               outcome.status = kdq_pkg::ST_FULL;
            end else begin
               held_keys[(head_slot + held_count) % QUEUE_DEPTH] = beat.key;
               held_count++;
            end
         end
         kdq_pkg::OP_POP_FRONT: begin
            if (held_count == 0) begin
               outcome.status = kdq_pkg::ST_EMPTY;
            end else begin
               head_slot = (head_slot + 1) % QUEUE_DEPTH;
               held_count--;
            end
         end
         kdq_pkg::OP_POP_BACK: begin
            if (held_count == 0) begin
               outcome.status = kdq_pkg::ST_EMPTY;
            end else begin
               held_count--;
            end
         end
         kdq_pkg::OP_LOOKUP: begin
            // search live entries only; the head pointer is not reset when the deque empties
            for (int i = 0; i < held_count; i++) begin
               if (held_keys[(head_slot + i) % QUEUE_DEPTH] == beat.key) begin
                  outcome.found = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
      outcome.entry_count = kdq_pkg::CountFieldBits'(held_count);
      if (outcome.status == kdq_pkg::ST_FULL) full_refusals++;
      if (outcome.status == kdq_pkg::ST_EMPTY) empty_refusals++;
      if (outcome.found) lookup_hits++;
      return outcome;
   endfunction

   always @(posedge clock) begin : watch_beats
      kdq_pkg::rsp_type want;
      if (reset) begin
         head_slot = 0;
         held_count = 0;
         awaited_results.delete();
      end else begin
         if (req_valid && !req_stall) begin
            awaited_results.push_back(apply_deque_op(req_data));
         end
         if (rsp_valid && !rsp_stall) begin
            if (awaited_results.size() == 0) begin
               report_mismatch($sformatf("result beat with nothing awaited (status %0d count %0d)",
                                         rsp_data.status, rsp_data.entry_count));
            end else begin
               want = awaited_results.pop_front();
               if (rsp_data.status !== want.status) begin
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            rsp_data.status, want.status));
               end
               if (rsp_data.found !== want.found) begin
                  report_mismatch($sformatf("found %0b, expected %0b",
                                            rsp_data.found, want.found));
               end
               if (rsp_data.entry_count !== want.entry_count) begin
                  report_mismatch($sformatf("entry_count %0d, expected %0d",
                                            rsp_data.entry_count, want.entry_count));
               end
            end
         end
      end
      fail_count <= mismatches;
      pending_count <= awaited_results.size();
      refused_push_count <= full_refusals;
      refused_pop_count <= empty_refusals;
      lookup_hit_count <= lookup_hits;
   end

endmodule

@@ dv/keyed_double_ended_queue_unit_tb.sv @@
`timescale 1ns / 1ps

module keyed_double_ended_queue_unit_tb;

   localparam int QuietLimit = 4000;
   localparam int ItemsPerPhase = 290;
   localparam int LongHoldCycles = 60;
   localparam int DrainCycles = 8;
   localparam int PoolSize = 8;
   localparam logic [2:0] OpFirstUnused = 3'd5;
   localparam logic [2:0] OpLastUnused = 3'd7;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   kdq_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   kdq_pkg::rsp_type rsp_data;

   int fail_count;
   int pending_count;
   int refused_push_count;
   int refused_pop_count;
   int lookup_hit_count;

   int send_idle_pct = 0;
   int take_idle_pct = 0;
   int run_phase = 0;
   int seen_phase = 0;
   int hold_left = 0;
   int quiet_cycles = 0;
   int beats_sent = 0;
   logic [kdq_pkg::KeyFieldBits-1:0] key_pool [PoolSize];
   int pool_slot = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   keyed_double_ended_queue_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   kdq_deque_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data           (req_data),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_data           (rsp_data),
      .fail_count         (fail_count),
      .pending_count      (pending_count),
      .refused_push_count (refused_push_count),
      .refused_pop_count  (refused_pop_count),
      .lookup_hit_count   (lookup_hit_count)
   );

   // Result side: a long hold-off at the start of each random phase, random stalls otherwise.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (run_phase != seen_phase) begin
         seen_phase <= run_phase;
         hold_left <= LongHoldCycles;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < take_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
         $display("keyed_double_ended_queue_unit_tb: FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_beat(input logic [2:0] beat_op,
                            input logic [kdq_pkg::KeyFieldBits-1:0] beat_key);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{op: beat_op, key: beat_key};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      beats_sent++;
      if (beat_op == kdq_pkg::OP_PUSH_FRONT || beat_op == kdq_pkg::OP_PUSH_BACK) begin
         key_pool[pool_slot] = beat_key;
         pool_slot = (pool_slot + 1) % PoolSize;
      end
   endtask

   // Drop valid and hold until every awaited result has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   function automatic logic [kdq_pkg::KeyFieldBits-1:0] pick_key();
      int roll;
      roll = $urandom_range(99);
      if (roll < 45) return key_pool[$urandom_range(PoolSize - 1)];
      if (roll < 55) begin
         case ($urandom_range(3))
            0: return '0;
            1: return '1;
            2: return {1'b1, {(kdq_pkg::KeyFieldBits - 1){1'b0}}};
            default: return {{(kdq_pkg::KeyFieldBits - 1){1'b0}}, 1'b1};
         endcase
      end
      return $urandom;
   endfunction

   function automatic logic [2:0] pick_op(input bit filling);
      int roll;
      roll = $urandom_range(99);
      if (roll < 4) return 3'($urandom_range(OpLastUnused, OpFirstUnused));
      if (roll < 26) return kdq_pkg::OP_LOOKUP;
      if (roll < (filling ? 86 : 40)) begin
         return $urandom_range(1) ? kdq_pkg::OP_PUSH_BACK : kdq_pkg::OP_PUSH_FRONT;
      end
      return $urandom_range(1) ? kdq_pkg::OP_POP_BACK : kdq_pkg::OP_POP_FRONT;
   endfunction

   task automatic run_directed();
      send_beat(kdq_pkg::OP_LOOKUP, '0);
      send_beat(kdq_pkg::OP_POP_FRONT, '1);
      send_beat(kdq_pkg::OP_POP_BACK, '0);
      send_beat(OpFirstUnused, 32'h1234_5678);
      send_beat(OpFirstUnused + 3'd1, '1);
      send_beat(OpLastUnused, '0);
      send_beat(kdq_pkg::OP_PUSH_FRONT, '0);
      send_beat(kdq_pkg::OP_PUSH_BACK, '1);
      send_beat(kdq_pkg::OP_LOOKUP, '0);
      send_beat(kdq_pkg::OP_LOOKUP, '1);
      send_beat(kdq_pkg::OP_LOOKUP, 32'h0000_0001);
      // fill to capacity from both ends, one duplicate among them, then push past it
      send_beat(kdq_pkg::OP_PUSH_BACK, '1);
      for (int i = 0; i < 13; i++) begin
         send_beat(i[0] ? kdq_pkg::OP_PUSH_FRONT : kdq_pkg::OP_PUSH_BACK, $urandom);
      end
      send_beat(kdq_pkg::OP_PUSH_FRONT, 32'hA5A5_A5A5);
      send_beat(kdq_pkg::OP_PUSH_BACK, 32'h5A5A_5A5A);
      send_beat(kdq_pkg::OP_LOOKUP, '1);
      send_beat(kdq_pkg::OP_POP_FRONT, '0);
      send_beat(kdq_pkg::OP_POP_BACK, '0);
   endtask

   task automatic run_random(input int count);
      logic [2:0] op;
      bit filling;
      int swing_left;
      filling = 1'b1;
      swing_left = $urandom_range(60, 25);
      for (int n = 0; n < count; n++) begin
         // swing between filling and emptying so both ends get hit often
         if (swing_left == 0) begin
            filling = !filling;
            swing_left = $urandom_range(60, 25);
         end
         swing_left--;
         op = pick_op(filling);
         send_beat(op, pick_key());
      end
   endtask

   initial begin
      for (int i = 0; i < PoolSize; i++) key_pool[i] = $urandom;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      drain_results();

      send_idle_pct = 19;
      take_idle_pct <= 74;
      run_phase <= 1;
      run_random(ItemsPerPhase);
      drain_results();

      send_idle_pct = 74;
      take_idle_pct <= 19;
      run_phase <= 2;
      run_random(ItemsPerPhase);
      drain_results();

      send_idle_pct = 0;
      take_idle_pct <= 0;
      run_phase <= 3;
      run_random(ItemsPerPhase);
      drain_results();

      $display("Run covered %0d request beats across three stall mixes.", beats_sent);
      $display("Seen: %0d pushes refused full, %0d pops refused empty, %0d lookup hits.",
               refused_push_count, refused_pop_count, lookup_hit_count);
      if (fail_count == 0) begin
         $display("keyed_double_ended_queue_unit_tb: PASS");
      end else begin
         $display("keyed_double_ended_queue_unit_tb: FAIL");
      end
      $finish;
   end

endmodule
